### src/parl_pkg.sv
package parl_pkg;

    // command codes
    localparam logic [1:0] CMD_CHECK     = 2'd0;
    localparam logic [1:0] CMD_BAN       = 2'd1;
    localparam logic [1:0] CMD_UNBAN     = 2'd2;
    localparam logic [1:0] CMD_WHITELIST = 2'd3;

    // verdict codes
    localparam logic [2:0] VERDICT_ALLOW      = 3'd0;
    localparam logic [2:0] VERDICT_ALLOW_WL   = 3'd1;
    localparam logic [2:0] VERDICT_DENY_BAN   = 3'd2;
    localparam logic [2:0] VERDICT_DENY_BKT   = 3'd3;
    localparam logic [2:0] VERDICT_DENY_FREQ  = 3'd4;
    localparam logic [2:0] VERDICT_TABLE_FULL = 3'd5;
    localparam logic [2:0] VERDICT_DONE       = 3'd6;

    // register indexes
    localparam logic [1:0] REG_CAPACITY   = 2'd0;
    localparam logic [1:0] REG_REFILL     = 2'd1;
    localparam logic [1:0] REG_MAX_WINDOW = 2'd2;
    localparam logic [1:0] REG_WINDOW_SEC = 2'd3;

    localparam logic [15:0] RST_CAPACITY   = 16'd100;
    localparam logic [15:0] RST_REFILL     = 16'd10;
    localparam logic [15:0] RST_MAX_WINDOW = 16'd100;
    localparam logic [15:0] RST_WINDOW_SEC = 16'd1;

    localparam int          DEFAULT_ENTRIES = 64;
    localparam int          MT_W            = 26;
    localparam int          TIME_W          = 48;
    localparam logic [9:0]  TOKEN_SCALE     = 10'd1000;
    localparam logic [MT_W-1:0] REQUEST_COST = MT_W'(1000);

    // one table entry as held in the memory
    typedef struct packed {
        logic              whitelisted;
        logic              banned;
        logic [TIME_W:0]   ban_expiry_ms;
        logic              limiters_made;
        logic [MT_W-1:0]   milli_tokens;
        logic [TIME_W-1:0] last_refill_ms;
        logic [15:0]       window_count;
        logic [TIME_W-1:0] window_start_ms;
    } entry_t;

endpackage

### src/per_address_rate_limiter.sv
// channel   | direction | signals
// ----------+-----------+----------------------------------------------------
// input     | in        | in_valid, in_stall, command, address, now_ms, ban_ttl_ms
// result    | out       | out_valid, out_stall, verdict
// config    | in        | cfg_write, cfg_index, cfg_data
//
// each item runs from transfer to result through key match, memory read,
// limiter setup with the refill multiply, then decision and write-back
// one item is in flight at a time; the entry memory read-modify-write sets this
// the result register frees the input side while a verdict waits on out_stall
// the decision cycle holds while the result register is full and out_stall is high
// reset clears the valid bits at once; no clearing pass is needed
module per_address_rate_limiter
    import parl_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] address,
    input  logic [47:0] now_ms,
    input  logic [31:0] ban_ttl_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  verdict,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_READ,
        S_CALC,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic                 out_valid_reg;
    logic [2:0]           verdict_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic [31:0]          key_reg [ENTRIES];
    logic [15:0]          capacity_reg, refill_reg, max_window_reg, window_sec_reg;

    // item registers
    logic [1:0]           command_reg;
    logic [31:0]          address_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [31:0]          ttl_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 hit_reg, fresh_reg, full_reg;

    // memory and pipeline registers
    entry_t               mem [ENTRIES];
    entry_t               rd_reg;
    entry_t               orig_reg;
    logic [2:0]           early_reg;
    logic                 early_hit_reg;
    logic [MT_W-1:0]      tok_b_reg;
    logic [15:0]          cnt_b_reg;
    logic [TIME_W-1:0]    start_b_reg;
    logic [41:0]          prod_reg;
    logic                 big_reg, later_reg;

    // key match over all entries
    logic [ENTRIES-1:0]   match_vec;
    logic [IDX_W-1:0]     hit_idx, free_idx;
    logic                 any_hit, any_free;

    always_comb
    begin
        match_vec = '0;
        hit_idx   = '0;
        free_idx  = '0;
        any_hit   = 1'b0;
        any_free  = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == address_reg);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
                any_hit = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    // derived register values
    logic [MT_W-1:0] cap_mt, win_len;
    assign cap_mt  = MT_W'(capacity_reg * TOKEN_SCALE);
    assign win_len = MT_W'(window_sec_reg * TOKEN_SCALE);

    // limiter setup from the entry read
    entry_t            ent;
    logic [TIME_W-1:0] last_b, elapsed;
    logic [MT_W-1:0]   tok_b;
    logic [15:0]       cnt_b;
    logic [TIME_W-1:0] start_b;
    logic              ban_live;
    logic [2:0]        early_v;
    logic              early_hit;

    always_comb
    begin
        ent = fresh_reg ? '0 : rd_reg;
        if (ent.limiters_made)
        begin
            tok_b   = ent.milli_tokens;
            last_b  = ent.last_refill_ms;
            cnt_b   = ent.window_count;
            start_b = ent.window_start_ms;
        end
        else
        begin
            tok_b   = cap_mt;
            last_b  = now_reg;
            cnt_b   = '0;
            start_b = now_reg;
        end
        elapsed  = now_reg - last_b;
        ban_live = ent.banned &&
                   ((ent.ban_expiry_ms == '0) || ({1'b0, now_reg} < ent.ban_expiry_ms));
        early_hit = 1'b1;
        early_v   = VERDICT_ALLOW_WL;
        if (ent.whitelisted)
        begin
            early_v = VERDICT_ALLOW_WL;
        end
        else if (ban_live)
        begin
            early_v = VERDICT_DENY_BAN;
        end
        else
        begin
            early_hit = 1'b0;
        end
    end

    // decision and new entry
    logic [42:0]       sum;
    logic [MT_W-1:0]   tok_r, tok_new;
    logic              over;
    logic [TIME_W:0]   win_end;
    logic [15:0]       cnt_new;
    logic [TIME_W-1:0] start_new;
    entry_t            wr_ent;
    logic              mem_we;
    logic [2:0]        fin_v;

    always_comb
    begin
        over    = big_reg || (prod_reg > 42'(cap_mt));
        sum     = 43'(tok_b_reg) + 43'(prod_reg);
        tok_r   = tok_b_reg;
        if (later_reg)
        begin
            if (over || (sum >= 43'(cap_mt)))
            begin
                tok_r = cap_mt;
            end
            else
            begin
                tok_r = sum[MT_W-1:0];
            end
        end
        tok_new   = tok_r - REQUEST_COST;
        win_end   = {1'b0, start_b_reg} + (TIME_W+1)'(win_len);
        start_new = start_b_reg;
        cnt_new   = cnt_b_reg;
        if ({1'b0, now_reg} >= win_end)
        begin
            start_new = now_reg;
            cnt_new   = '0;
        end
        if (cnt_new != 16'hFFFF)
        begin
            cnt_new = cnt_new + 16'd1;
        end

        wr_ent = orig_reg;
        fin_v  = VERDICT_DONE;
        mem_we = 1'b1;
        if (full_reg && !hit_reg && (command_reg != CMD_UNBAN))
        begin
            fin_v  = VERDICT_TABLE_FULL;
            mem_we = 1'b0;
        end
        else
        begin
            case (command_reg)
                CMD_CHECK:
                begin
                    if (early_hit_reg)
                    begin
                        fin_v = early_reg;
                    end
                    else
                    begin
                        wr_ent.limiters_made   = 1'b1;
                        wr_ent.last_refill_ms  = now_reg;
                        wr_ent.milli_tokens    = tok_r;
                        wr_ent.window_count    = cnt_b_reg;
                        wr_ent.window_start_ms = start_b_reg;
                        if ((capacity_reg == '0) || (tok_r < REQUEST_COST))
                        begin
                            fin_v = VERDICT_DENY_BKT;
                        end
                        else
                        begin
                            wr_ent.milli_tokens    = tok_new;
                            wr_ent.window_count    = cnt_new;
                            wr_ent.window_start_ms = start_new;
                            fin_v = (cnt_new > max_window_reg) ? VERDICT_DENY_FREQ
                                                               : VERDICT_ALLOW;
                        end
                    end
                end
                CMD_BAN:
                begin
                    wr_ent.banned        = 1'b1;
                    wr_ent.ban_expiry_ms = (ttl_reg == '0) ? '0
                        : ({1'b0, now_reg} + (TIME_W+1)'(ttl_reg));
                end
                CMD_UNBAN:
                begin
                    wr_ent.banned = 1'b0;
                    mem_we        = hit_reg;
                end
                default:
                begin
                    wr_ent.whitelisted = 1'b1;
                end
            endcase
        end
    end

    logic fin_go;
    assign fin_go = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // state, valid bits, config registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            verdict_reg    <= VERDICT_DONE;
            valid_reg      <= '0;
            capacity_reg   <= RST_CAPACITY;
            refill_reg     <= RST_REFILL;
            max_window_reg <= RST_MAX_WINDOW;
            window_sec_reg <= RST_WINDOW_SEC;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CAPACITY:   capacity_reg   <= cfg_data;
                    REG_REFILL:     refill_reg     <= cfg_data;
                    REG_MAX_WINDOW: max_window_reg <= cfg_data;
                    REG_WINDOW_SEC: window_sec_reg <= cfg_data;
                    default:        capacity_reg   <= capacity_reg;
                endcase
            end
            // result register: load on a finished item, else drop after its transfer
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:  state_reg <= S_READ;
                S_READ:   state_reg <= S_CALC;
                S_CALC:   state_reg <= S_FINISH;
                S_FINISH:
                begin
                    if (fin_go)
                    begin
                        verdict_reg   <= fin_v;
                        state_reg     <= S_IDLE;
                        if (mem_we)
                        begin
                            valid_reg[idx_reg] <= 1'b1;
                        end
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // payload and pipeline registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            command_reg <= command;
            address_reg <= address;
            now_reg     <= now_ms;
            ttl_reg     <= ban_ttl_ms;
        end
        if (state_reg == S_MATCH)
        begin
            hit_reg   <= any_hit;
            fresh_reg <= !any_hit;
            full_reg  <= !any_free;
            idx_reg   <= any_hit ? hit_idx : free_idx;
        end
        if (state_reg == S_CALC)
        begin
            orig_reg      <= ent;
            early_reg     <= early_v;
            early_hit_reg <= early_hit;
            tok_b_reg     <= tok_b;
            cnt_b_reg     <= cnt_b;
            start_b_reg   <= start_b;
            prod_reg      <= elapsed[MT_W-1:0] * refill_reg;
            big_reg       <= (refill_reg != '0) && (|elapsed[TIME_W-1:MT_W]);
            later_reg     <= now_reg > last_b;
        end
    end

    // entry memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_reg <= mem[idx_reg];
        end
        if (fin_go && mem_we)
        begin
            mem[idx_reg]     <= wr_ent;
            key_reg[idx_reg] <= address_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // addresses in the table stay unique
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |-> $onehot0(match_vec))
        else $error("address held in more than one entry");

    // a claimed entry was free before
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && mem_we && fresh_reg) |-> !valid_reg[idx_reg])
        else $error("claim overwrote a live entry");

    // one item in flight: an accepted item blocks the input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && (state_reg == S_MATCH)))
        else $error("second item accepted while busy");

    // table full only when no entry was free
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && (fin_v == VERDICT_TABLE_FULL)) |-> (&valid_reg))
        else $error("table full with a free entry");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import parl_pkg::*;

    localparam int SLOTS = DEFAULT_ENTRIES;
    localparam int POOL = 96;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_CHECK;
    logic [31:0] address = '0;
    logic [47:0] now_ms = '0;
    logic [31:0] ban_ttl_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  verdict;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_CAPACITY;
    logic [15:0] cfg_data = '0;

    per_address_rate_limiter uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .address(address), .now_ms(now_ms), .ban_ttl_ms(ban_ttl_ms),
        .out_valid(out_valid), .out_stall(out_stall), .verdict(verdict),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the address table and registers
    typedef struct {
        bit        vld;
        bit [31:0] addr;
        bit        wl;
        bit        bn;
        bit [48:0] expiry;
        bit        lim;
        bit [25:0] mtok;
        bit [47:0] last;
        bit [15:0] cnt;
        bit [47:0] wstart;
    } slot_t;

    slot_t     slots [SLOTS];
    bit [15:0] capacity_r = RST_CAPACITY;
    bit [15:0] refill_r = RST_REFILL;
    bit [15:0] max_win_r = RST_MAX_WINDOW;
    bit [15:0] win_sec_r = RST_WINDOW_SEC;

    logic [2:0] verdict_q [$];
    int         mismatches = 0;
    bit         quiet = 1'b0;

    // policing decision for one address that holds an entry
    function automatic logic [2:0] police_slot(int e, bit [47:0] now);
        bit [63:0] cap_mt;
        bit [63:0] elapsed;
        bit [63:0] add;
        bit [63:0] sum;
        cap_mt = 64'(capacity_r) * 1000;
        if (slots[e].wl)
            return VERDICT_ALLOW_WL;
        if (slots[e].bn && (slots[e].expiry == 0 || 49'(now) < slots[e].expiry))
            return VERDICT_DENY_BAN;
        if (!slots[e].lim)
        begin
            slots[e].lim = 1'b1;
            slots[e].mtok = 26'(cap_mt);
            slots[e].last = now;
            slots[e].cnt = 0;
            slots[e].wstart = now;
        end
        // refill
        if (now > slots[e].last)
        begin
            elapsed = 64'(now - slots[e].last);
            if (refill_r != 0 && elapsed > cap_mt / refill_r)
                add = cap_mt + 1;
            else
                add = elapsed * refill_r;
            sum = 64'(slots[e].mtok) + add;
            slots[e].mtok = 26'((sum < cap_mt) ? sum : cap_mt);
        end
        slots[e].last = now;
        if (capacity_r == 0 || slots[e].mtok < 26'd1000)
            return VERDICT_DENY_BKT;
        slots[e].mtok = slots[e].mtok - 26'd1000;
        // fixed window
        if (64'(now) >= 64'(slots[e].wstart) + 64'(win_sec_r) * 1000)
        begin
            slots[e].wstart = now;
            slots[e].cnt = 0;
        end
        if (slots[e].cnt != 16'hFFFF)
            slots[e].cnt = slots[e].cnt + 1;
        if (slots[e].cnt > max_win_r)
            return VERDICT_DENY_FREQ;
        return VERDICT_ALLOW;
    endfunction

    function automatic logic [2:0] predict_verdict(logic [1:0] cmd, bit [31:0] addr,
                                                   bit [47:0] now, bit [31:0] ttl);
        int e;
        e = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (slots[i].vld && slots[i].addr == addr)
                e = i;
        if (cmd == CMD_UNBAN)
        begin
            if (e >= 0)
                slots[e].bn = 1'b0;
            return VERDICT_DONE;
        end
        if (e < 0)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!slots[i].vld)
                    e = i;
            if (e < 0)
                return VERDICT_TABLE_FULL;
            slots[e] = '{vld: 1'b1, addr: addr, default: '0};
        end
        if (cmd == CMD_CHECK)
            return police_slot(e, now);
        if (cmd == CMD_BAN)
        begin
            slots[e].bn = 1'b1;
            slots[e].expiry = (ttl == 0) ? 49'd0 : 49'(now) + 49'(ttl);
        end
        else
            slots[e].wl = 1'b1;
        return VERDICT_DONE;
    endfunction

    // one input transfer, with an optional idle burst after it
    task automatic send_item(logic [1:0] cmd, bit [31:0] addr, bit [47:0] now,
                             bit [31:0] ttl, bit typed, logic [2:0] typed_v);
        logic [2:0] v;
        in_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        now_ms <= now;
        ban_ttl_ms <= ttl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v = predict_verdict(cmd, addr, now, ttl);
        verdict_q.push_back(typed ? typed_v : v);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_regs(bit [15:0] cap, bit [15:0] rate, bit [15:0] maxw,
                              bit [15:0] wsec);
        logic [1:0] idx [4];
        bit [15:0]  val [4];
        idx = '{REG_CAPACITY, REG_REFILL, REG_MAX_WINDOW, REG_WINDOW_SEC};
        val = '{cap, rate, maxw, wsec};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        capacity_r = cap;
        refill_r = rate;
        max_win_r = maxw;
        win_sec_r = wsec;
        @(posedge clk);
    endtask

    // result side stall bursts
    initial
    begin
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: verdict %0d", verdict);
            end
            else
            begin
                if (verdict !== verdict_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected %0d got %0d",
                                 verdict_q[0], verdict);
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    // directed rows
    typedef struct {
        logic [1:0] cmd;
        bit [31:0]  addr;
        bit [47:0]  now;
        bit [31:0]  ttl;
        bit         typed;
        logic [2:0] v;
    } row_t;

    localparam bit [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

    row_t rows [15] = '{
        '{CMD_CHECK,     32'h0000_0000, 48'd0,    32'd0,   1'b1, VERDICT_ALLOW},
        '{CMD_WHITELIST, 32'hFFFF_FFFF, 48'd1,    32'd0,   1'b1, VERDICT_DONE},
        '{CMD_CHECK,     32'hFFFF_FFFF, 48'd2,    32'd0,   1'b1, VERDICT_ALLOW_WL},
        '{CMD_BAN,       32'h1234_5678, 48'd3,    32'd0,   1'b1, VERDICT_DONE},
        '{CMD_CHECK,     32'h1234_5678, 48'd5,    32'd0,   1'b1, VERDICT_DENY_BAN},
        '{CMD_UNBAN,     32'h1234_5678, 48'd6,    32'd0,   1'b1, VERDICT_DONE},
        '{CMD_CHECK,     32'h1234_5678, 48'd7,    32'd0,   1'b1, VERDICT_ALLOW},
        '{CMD_UNBAN,     32'hAAAA_5555, 48'd8,    32'd0,   1'b1, VERDICT_DONE},
        '{CMD_BAN,       32'h5555_AAAA, 48'd1000, 32'd100, 1'b1, VERDICT_DONE},
        '{CMD_CHECK,     32'h5555_AAAA, 48'd1099, 32'd0,   1'b1, VERDICT_DENY_BAN},
        '{CMD_CHECK,     32'h5555_AAAA, 48'd1100, 32'd0,   1'b0, VERDICT_ALLOW},
        '{CMD_BAN,       32'h0F0F_F0F0, T_MAX,    32'hFFFF_FFFF, 1'b1, VERDICT_DONE},
        '{CMD_CHECK,     32'h0F0F_F0F0, T_MAX,    32'd0,   1'b1, VERDICT_DENY_BAN},
        '{CMD_CHECK,     32'h0000_0000, T_MAX,    32'd0,   1'b0, VERDICT_ALLOW},
        '{CMD_CHECK,     32'h0000_0000, 48'd0,    32'd0,   1'b0, VERDICT_ALLOW}
    };

    // register settings per random phase: capacity, refill, window max, window seconds
    bit [15:0] phase_cfg [6][4] = '{
        '{16'd0,     16'd65535, 16'd0,     16'd0},
        '{16'd4,     16'd1,     16'd3,     16'd2},
        '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
        '{16'd2,     16'd0,     16'd1,     16'd1},
        '{16'd10,    16'd5,     16'd5,     16'd1},
        '{16'd1,     16'd1000,  16'd2,     16'd0}
    };
    int phase_pool [6] = '{6, 10, 14, 20, 24, POOL};

    bit [31:0] pool [POOL];

    // stimulus
    initial
    begin
        bit [47:0]  clock_ms;
        logic [1:0] cmd;
        bit [31:0]  addr;
        bit [31:0]  ttl;
        int         pick;

        for (int i = 0; i < SLOTS; i++)
            slots[i] = '{default: '0};
        for (int i = 0; i < POOL; i++)
            pool[i] = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].addr, rows[i].now, rows[i].ttl,
                      rows[i].typed, rows[i].v);
        drain();

        clock_ms = 48'd10000;
        for (int p = 0; p < 6; p++)
        begin
            write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            quiet = (p == 5);
            for (int n = 0; n < 105; n++)
            begin
                // time mostly moves forward, now and then back or far ahead
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    clock_ms = clock_ms + $urandom_range(0, 300);
                else if (pick < 90)
                    clock_ms = clock_ms + $urandom_range(0, 5000);
                else if (pick < 95)
                    clock_ms = clock_ms - ((clock_ms > 3000) ? $urandom_range(0, 2000) : 0);
                else
                    clock_ms = clock_ms + $urandom;
                addr = ($urandom_range(0, 99) < 3) ? $urandom
                                                   : pool[$urandom_range(0, phase_pool[p] - 1)];
                pick = $urandom_range(0, 99);
                ttl = 0;
                if (pick < 82)
                    cmd = CMD_CHECK;
                else if (pick < 91)
                begin
                    cmd = CMD_BAN;
                    pick = $urandom_range(0, 3);
                    ttl = (pick < 2) ? $urandom_range(0, 3000) : ((pick == 2) ? 0 : $urandom);
                end
                else if (pick < 98)
                    cmd = CMD_UNBAN;
                else
                    cmd = CMD_WHITELIST;
                if (cmd != CMD_BAN && $urandom_range(0, 1) == 0)
                    ttl = $urandom;
                send_item(cmd, addr, clock_ms, ttl, 1'b0, VERDICT_DONE);
            end
            // sender holds off until every verdict is back
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

### files.f
src/parl_pkg.sv
src/per_address_rate_limiter.sv
dv/testbench.sv
